/* hdl/page_free_list_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Page free list allocator assertion macros
// Shared concurrent assertion forms, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled in reset.
`define PFLA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and disabled in reset.
`define PFLA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFLA_ASSERT_IMP(label, ante, cons, msg)
`define PFLA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

/* hdl/pfla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator package
// Widths, codes and the command bundle shared by the allocator modules.
// ----------------------------------------------------------------------------
package pfla_pkg;

	localparam int PAGE_W     = 12;
	localparam int CNT_W      = 13;
	localparam int LINK_DEPTH = 4096;

	// Largest page count the 12-bit page index can address.
	localparam logic [CNT_W-1:0] PAGE_CAP = 13'd4096;
	localparam logic [CNT_W-1:0] CNT_ALL_ONES = 13'h1FFF;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_ILLEGAL = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // latch the request and read the link at the head
		logic exec;     // apply the update and register the result
	} ctrl_cmd_t;

endpackage

/* hdl/pfla_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator controller
// Two-state sequencer: accept a request, then execute it and strobe the result.
// ----------------------------------------------------------------------------
module pfla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output pfla_pkg::ctrl_cmd_t cmd
);
	import pfla_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && start;
	assign cmd.exec   = (state_q == S_EXEC);
	assign done       = done_q;

endmodule

/* hdl/pfla_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator datapath
// Link memory, list head, counters, limit register and result registers.
// ----------------------------------------------------------------------------
module pfla_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfla_pkg::ctrl_cmd_t         cmd,
	input  logic                        op,
	input  logic [pfla_pkg::PAGE_W-1:0] page_index,
	input  logic                        cfg_we,
	input  logic [pfla_pkg::CNT_W-1:0]  cfg_wdata,
	output logic [1:0]                  status,
	output logic [pfla_pkg::PAGE_W-1:0] page_out,
	output logic [pfla_pkg::CNT_W-1:0]  free_count,
	output logic [pfla_pkg::CNT_W-1:0]  in_use_pages,
	output logic [pfla_pkg::CNT_W-1:0]  available_pages,
	output logic                        limit_off
);
	import pfla_pkg::*;

	logic [PAGE_W-1:0] link_mem [LINK_DEPTH];
	logic [PAGE_W-1:0] link_rd_q;

	logic              op_q;
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] free_head_q;
	logic [CNT_W-1:0]  free_total_q;
	logic [CNT_W-1:0]  high_water_q;
	logic [CNT_W-1:0]  max_pages_q;

	logic [1:0]        status_q;
	logic [PAGE_W-1:0] page_out_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  in_use_q;
	logic [CNT_W-1:0]  avail_q;
	logic              limit_off_q;

	logic [CNT_W-1:0]  eff_limit;
	status_t           status_nxt;
	logic [PAGE_W-1:0] page_out_nxt;
	logic [PAGE_W-1:0] head_nxt;
	logic [CNT_W-1:0]  total_nxt;
	logic [CNT_W-1:0]  hw_nxt;
	logic              push_ok;
	logic [CNT_W:0]    avail_sum;
	logic [CNT_W:0]    avail_diff;
	logic [CNT_W-1:0]  avail_nxt;

	// A limit of zero or above the index range acts as the index range.
	assign eff_limit = ((max_pages_q == '0) || (max_pages_q > PAGE_CAP)) ?
		PAGE_CAP : max_pages_q;

	always_comb begin
		status_nxt   = ST_OK;
		page_out_nxt = '0;
		head_nxt     = free_head_q;
		total_nxt    = free_total_q;
		hw_nxt       = high_water_q;
		push_ok      = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (free_total_q != '0) begin
				page_out_nxt = free_head_q;
				total_nxt    = free_total_q - 13'd1;
				head_nxt     = (total_nxt == '0) ? '0 : link_rd_q;
			end else if (high_water_q < eff_limit) begin
				page_out_nxt = high_water_q[PAGE_W-1:0];
				hw_nxt       = high_water_q + 13'd1;
			end else begin
				status_nxt = ST_FULL;
			end
		end else begin
			// With every used page already listed, a further free is a double free.
			if ((page_q == '0) || ({1'b0, page_q} >= high_water_q) ||
					((free_total_q + 13'd1) >= high_water_q)) begin
				status_nxt = ST_ILLEGAL;
			end else begin
				push_ok   = 1'b1;
				head_nxt  = page_q;
				total_nxt = free_total_q + 13'd1;
			end
		end
	end

	assign avail_sum  = {1'b0, eff_limit} + {1'b0, total_nxt};
	assign avail_diff = avail_sum - {1'b0, hw_nxt};
	assign avail_nxt  = (avail_sum < {1'b0, hw_nxt}) ? '0 : avail_diff[CNT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			link_rd_q <= link_mem[free_head_q];
		end
		if (cmd.exec && push_ok) begin
			link_mem[page_q] <= free_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			page_q <= page_index;
		end
		if (cmd.exec) begin
			status_q     <= status_nxt;
			page_out_q   <= page_out_nxt;
			free_count_q <= total_nxt;
			in_use_q     <= hw_nxt - total_nxt;
			avail_q      <= (max_pages_q == '0) ? CNT_ALL_ONES : avail_nxt;
			limit_off_q  <= (max_pages_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			free_total_q <= '0;
			high_water_q <= 13'd1;
			max_pages_q  <= '0;
		end else begin
			if (cmd.exec) begin
				free_head_q  <= head_nxt;
				free_total_q <= total_nxt;
				high_water_q <= hw_nxt;
			end
			if (cfg_we) begin
				max_pages_q <= cfg_wdata;
			end
		end
	end

	assign status          = status_q;
	assign page_out        = page_out_q;
	assign free_count      = free_count_q;
	assign in_use_pages    = in_use_q;
	assign available_pages = avail_q;
	assign limit_off       = limit_off_q;

endmodule

/* hdl/page_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator
// LIFO free list of pages linked through a 4096 x 12 link memory.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, busy            op, page_index
//  result    done (one cycle)       status, page_out, free_count,
//                                   in_use_pages, available_pages, limit_off
//  config    cfg_we                 cfg_wdata (max_pages)
//
// Each request has an accept cycle, which reads the link memory at the list
// head, and an execute cycle, which updates head, counts and memory.
// The result strobes on done the cycle after execute; a new start may be
// accepted in that same cycle, but not while busy in the execute cycle.
// Reset empties the list; the link memory is not cleared and needs no pass.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`include "page_free_list_allocator_defines.svh"

module page_free_list_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [pfla_pkg::PAGE_W-1:0] page_index,
	input  logic                        cfg_we,
	input  logic [pfla_pkg::CNT_W-1:0]  cfg_wdata,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [pfla_pkg::PAGE_W-1:0] page_out,
	output logic [pfla_pkg::CNT_W-1:0]  free_count,
	output logic [pfla_pkg::CNT_W-1:0]  in_use_pages,
	output logic [pfla_pkg::CNT_W-1:0]  available_pages,
	output logic                        limit_off
);
	import pfla_pkg::*;

	ctrl_cmd_t cmd;

	pfla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	pfla_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (op),
		.page_index      (page_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.status          (status),
		.page_out        (page_out),
		.free_count      (free_count),
		.in_use_pages    (in_use_pages),
		.available_pages (available_pages),
		.limit_off       (limit_off)
	);

	// An accepted request occupies the execute cycle.
	`PFLA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
	// The result strobe lands after execute, when the block is free again.
	`PFLA_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
	// A refused allocation hands out no page.
	`PFLA_ASSERT_IMP(a_full_page, done && (status == ST_FULL), page_out == '0,
		"full status with a page")
	// The header page is always in use.
	`PFLA_ASSERT_IMP(a_in_use, done, in_use_pages != '0, "in-use count dropped to zero")
	// Without a limit, availability reads as unbounded.
	`PFLA_ASSERT_IMP(a_unbounded, done && limit_off, available_pages == CNT_ALL_ONES,
		"unbounded availability not all ones")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator testbench
// Drives allocate and free requests through the start/busy handshake and
// follows each transfer with an internal free-list model that tracks the
// links, head, counts, high-water mark and page limit. Every result strobe is
// compared field by field with the oldest outstanding prediction. Directed
// cases cover LIFO reuse, illegal frees and limits. Random phases then mix
// traffic under varying limits, and a last pass fills the page space up to a
// limit set just above the high-water mark.
// ----------------------------------------------------------------------------
module tb;
	import pfla_pkg::*;

	typedef struct {
		status_t            status;
		logic [PAGE_W-1:0]  page;
		logic [CNT_W-1:0]   free_cnt;
		logic [CNT_W-1:0]   in_use;
		logic [CNT_W-1:0]   avail;
		logic               unlimited;
	} page_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               op = OP_ALLOC;
	logic [PAGE_W-1:0]  page_index = '0;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [PAGE_W-1:0]  page_out;
	logic [CNT_W-1:0]   free_count;
	logic [CNT_W-1:0]   in_use_pages;
	logic [CNT_W-1:0]   available_pages;
	logic               limit_off;

	// Free-list state as the allocator should hold it.
	logic [PAGE_W-1:0]  link_mem [LINK_DEPTH];
	logic [PAGE_W-1:0]  head_pg = '0;
	int                 free_cnt = 0;
	int                 hwm = 1;
	int                 limit_reg = 0;

	page_result_t       page_results_due[$];
	logic [PAGE_W-1:0]  held_pages[$];
	int                 mismatches = 0;

	page_free_list_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.page_index      (page_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.status          (status),
		.page_out        (page_out),
		.free_count      (free_count),
		.in_use_pages    (in_use_pages),
		.available_pages (available_pages),
		.limit_off       (limit_off)
	);

	always #5 clk = ~clk;

	// Applies one request to the free-list state and returns its result.
	function automatic page_result_t apply_page_request(logic o, logic [PAGE_W-1:0] pg);
		page_result_t r;
		int lim_eff;
		int avail;
		int i;
		r.status = ST_OK;
		r.page = '0;
		lim_eff = (limit_reg == 0 || limit_reg > int'(PAGE_CAP)) ? int'(PAGE_CAP) : limit_reg;
		if (o == OP_ALLOC) begin
			if (free_cnt > 0) begin
				r.page = head_pg;
				free_cnt--;
				head_pg = (free_cnt == 0) ? '0 : link_mem[r.page];
				held_pages.push_back(r.page);
			end else if (hwm < lim_eff) begin
				r.page = hwm[PAGE_W-1:0];
				hwm++;
				held_pages.push_back(r.page);
			end else begin
				r.status = ST_FULL;
			end
		end else begin
			// A free with every page already on the list can only be a double free.
			if (pg == 0 || int'(pg) >= hwm || free_cnt + 1 >= hwm) begin
				r.status = ST_ILLEGAL;
			end else begin
				link_mem[pg] = head_pg;
				head_pg = pg;
				free_cnt++;
				for (i = 0; i < held_pages.size(); i++) begin
					if (held_pages[i] == pg) begin
						held_pages.delete(i);
						break;
					end
				end
			end
		end
		r.free_cnt = free_cnt[CNT_W-1:0];
		r.in_use = (hwm >= free_cnt) ? CNT_W'(hwm - free_cnt) : '0;
		if (limit_reg == 0) begin
			r.avail = CNT_ALL_ONES;
			r.unlimited = 1'b1;
		end else begin
			avail = lim_eff - hwm + free_cnt;
			if (avail < 0)
				avail = 0;
			if (avail > int'(CNT_ALL_ONES))
				avail = int'(CNT_ALL_ONES);
			r.avail = CNT_W'(avail);
			r.unlimited = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		page_result_t exp_r;
		if (arst_n && done) begin
			if (page_results_due.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatches++;
			end else begin
				exp_r = page_results_due.pop_front();
				check_field("status", exp_r.status, status);
				check_field("page_out", exp_r.page, page_out);
				check_field("free_count", exp_r.free_cnt, free_count);
				check_field("in_use_pages", exp_r.in_use, in_use_pages);
				check_field("available_pages", exp_r.avail, available_pages);
				check_field("limit_off", exp_r.unlimited, limit_off);
			end
		end
	end

	// Holds start high until the transfer happens; start stays high afterwards
	// so that back-to-back requests need no extra cycle.
	task automatic send_request(input logic o, input logic [PAGE_W-1:0] pg, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		page_index <= pg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		page_results_due.push_back(apply_page_request(o, pg));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (page_results_due.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_limit(input int v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
		@(posedge clk);
	endtask

	function automatic int idle_gap(input bit allow);
		if (allow && $urandom_range(3) == 0)
			return $urandom_range(1, 16);
		return 0;
	endfunction

	// Fresh pages come out in order and freed pages come back last in, first out.
	task automatic test_alloc_free_basic();
		send_request(OP_ALLOC, '1, 0);
		send_request(OP_ALLOC, '1, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_FREE, 12'd2, 0);
		send_request(OP_FREE, 12'd1, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '1, 0);
		send_request(OP_FREE, 12'd3, 0);
		send_request(OP_ALLOC, '0, 0);
	endtask

	task automatic test_illegal_free();
		send_request(OP_FREE, 12'd0, 0);
		send_request(OP_FREE, 12'hFFF, 0);
		send_request(OP_FREE, PAGE_W'(hwm), 0);
		send_request(OP_FREE, 12'd1, 0);
		send_request(OP_FREE, 12'd2, 0);
		send_request(OP_FREE, 12'd3, 0);
		// Every page above the header and below the high-water mark is now free, so this is a double free.
		send_request(OP_FREE, 12'd1, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
	endtask

	task automatic test_limits();
		// A limit below the high-water mark refuses fresh pages but not reused ones.
		set_limit(1);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_FREE, 12'd2, 0);
		send_request(OP_ALLOC, '0, 0);
		set_limit(6);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
		set_limit(4096);
		send_request(OP_ALLOC, '0, 0);
		set_limit(8191);
		send_request(OP_ALLOC, '0, 0);
		set_limit(0);
		send_request(OP_FREE, 12'd7, 0);
	endtask

	task automatic test_random_traffic();
		int lim;
		int alloc_pct;
		int pick;
		bit allow_idle;
		logic [PAGE_W-1:0] pg;
		for (int phase = 0; phase < 9; phase++) begin
			case ($urandom_range(7))
				0: lim = 0;
				1: lim = 1;
				2: lim = hwm;
				3: lim = hwm + $urandom_range(1, 40);
				4: lim = $urandom_range(1, hwm);
				5: lim = 4096;
				6: lim = $urandom_range(4097, 8191);
				default: lim = $urandom_range(0, 8191);
			endcase
			set_limit(lim);
			alloc_pct = $urandom_range(35, 75);
			allow_idle = (phase % 3 != 2);
			repeat (100) begin
				pick = $urandom_range(99);
				if (pick < alloc_pct) begin
					send_request(OP_ALLOC, PAGE_W'($urandom()), idle_gap(allow_idle));
				end else begin
					pick = $urandom_range(99);
					if (pick < 80 && held_pages.size() > 0)
						pg = held_pages[$urandom_range(held_pages.size() - 1)];
					else if (pick < 90)
						pg = PAGE_W'($urandom());
					else if (pick < 96)
						pg = PAGE_W'($urandom_range(0, hwm));
					else
						pg = head_pg;
					send_request(OP_FREE, pg, idle_gap(allow_idle));
				end
			end
		end
	endtask

	// Fills pages up to a limit just above the high-water mark, with no idle cycles.
	task automatic test_page_cap();
		int fill_lim;
		fill_lim = hwm + 120;
		set_limit(fill_lim);
		while (hwm < fill_lim) begin
			if ($urandom_range(19) == 0 && held_pages.size() > 0)
				send_request(OP_FREE, held_pages[$urandom_range(held_pages.size() - 1)], 0);
			else
				send_request(OP_ALLOC, PAGE_W'($urandom()), 0);
		end
		while (free_cnt > 0)
			send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '1, 0);
		send_request(OP_FREE, 12'hFFF, 0);
		send_request(OP_FREE, 12'h800, 0);
		send_request(OP_ALLOC, '0, 0);
		set_limit(8191);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
		set_limit(4096);
		send_request(OP_FREE, 12'hABC, 0);
		set_limit(100);
		send_request(OP_FREE, 12'h555, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
		send_request(OP_ALLOC, '0, 0);
		set_limit(0);
		repeat (60) begin
			if ($urandom_range(1) == 0 && held_pages.size() > 0)
				send_request(OP_FREE, held_pages[$urandom_range(held_pages.size() - 1)], 0);
			else
				send_request(OP_ALLOC, PAGE_W'($urandom()), 0);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alloc_free_basic();
		test_illegal_free();
		test_limits();
		test_random_traffic();
		test_page_cap();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("page_free_list_allocator: match");
		else
			$display("page_free_list_allocator: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("page_free_list_allocator: mismatch");
		$finish;
	end

endmodule
